// ===== rtl/core/eul_pkg.sv =====
`timescale 1ns / 1ps

package eul_pkg;

    localparam int ANGLE_WIDTH    = 16;
    localparam int IN_WIDTH       = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int OUT_WIDTH      = QUAT_FRAC_BITS + 2;
    localparam int IFRAC          = 30;
    localparam int VAL_WIDTH      = IFRAC + 2;

    localparam logic [31:0] PI_Q30 = 32'hC90F_DAA2;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    localparam int SIN_STEPS = 6;
    localparam int COS_STEPS = 7;

    // divisors and floor(2^32 / divisor) of each series step, index 0 unused
    localparam logic [7:0] SIN_DIV [0:7] = '{8'd1, 8'd6, 8'd20, 8'd42, 8'd72,
                                             8'd110, 8'd156, 8'd1};
    localparam logic [31:0] SIN_RECIP [0:7] = '{32'd0, 32'd715827882, 32'd214748364,
                                                32'd102261126, 32'd59652323,
                                                32'd39045157, 32'd27531841, 32'd0};
    localparam logic [7:0] COS_DIV [0:7] = '{8'd1, 8'd2, 8'd12, 8'd30, 8'd56,
                                             8'd90, 8'd132, 8'd182};
    localparam logic [31:0] COS_RECIP [0:7] = '{32'd0, 32'd2147483648, 32'd357913941,
                                                32'd143165576, 32'd76695844,
                                                32'd47721858, 32'd32537631, 32'd23598721};

    // register stages from the angle register to the sine and cosine outputs
    localparam int SC_LAT = 3 * COS_STEPS + 3;
    // input register, series, three product and sum stages, output register
    localparam int PIPE_DEPTH = 1 + SC_LAT + 4;

endpackage

// ===== rtl/core/eul_sincos.sv =====
`timescale 1ns / 1ps

module eul_sincos (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [eul_pkg::ANGLE_WIDTH-1:0]     i_angle,
    output logic signed [eul_pkg::VAL_WIDTH-1:0] o_sin,
    output logic signed [eul_pkg::VAL_WIDTH-1:0] o_cos
);

    typedef struct packed {
        logic               neg;
        logic [31:0]        x2;
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic signed [33:0] as;
        logic signed [33:0] ac;
        logic [31:0]        ps;
        logic [31:0]        pc;
        logic [31:0]        qs;
        logic [31:0]        qc;
    } t_sc_st;

    localparam int NST = 3 * eul_pkg::COS_STEPS + 1;
    localparam int AW  = eul_pkg::ANGLE_WIDTH;

    logic                   r_neg1;
    logic [31:0]            r_t1;
    logic [AW-1:0]          n_mag;
    logic [AW+32:0]         n_tprod;
    logic [63:0]            n_tsq;
    t_sc_st                 n_st0;
    t_sc_st                 r_st [0:NST-1];

    assign n_mag   = i_angle[AW-1] ? (AW'(0) - i_angle) : i_angle;
    assign n_tprod = (AW+33)'(n_mag) * (AW+33)'(eul_pkg::PI_Q30)
                   + ((AW+33)'(1) << (AW - 1));
    assign n_tsq   = 64'(r_t1) * 64'(r_t1);

    always_comb begin
        n_st0     = '0;
        n_st0.neg = r_neg1;
        n_st0.x2  = n_tsq[61:30];
        n_st0.ts  = r_t1;
        n_st0.tc  = eul_pkg::ONE_Q30;
        n_st0.as  = 34'(r_t1);
        n_st0.ac  = 34'(eul_pkg::ONE_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1  <= i_angle[AW-1];
            r_t1    <= n_tprod[AW+31:AW];
            r_st[0] <= n_st0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= eul_pkg::COS_STEPS; k++) begin : g_step
            logic [63:0] n_ps;
            logic [63:0] n_pc;
            logic [63:0] n_qs;
            logic [63:0] n_qc;
            logic [39:0] n_rs;
            logic [39:0] n_rc;
            logic [31:0] n_sq;
            logic [31:0] n_cq;
            t_sc_st      n_st_mul;
            t_sc_st      n_st_rcp;
            t_sc_st      n_st_fix;

            assign n_ps = 64'(r_st[3*k-3].ts) * 64'(r_st[3*k-3].x2);
            assign n_pc = 64'(r_st[3*k-3].tc) * 64'(r_st[3*k-3].x2);
            assign n_qs = 64'(r_st[3*k-2].ps) * 64'(eul_pkg::SIN_RECIP[k]);
            assign n_qc = 64'(r_st[3*k-2].pc) * 64'(eul_pkg::COS_RECIP[k]);
            assign n_rs = 40'(r_st[3*k-1].ps)
                        - 40'(r_st[3*k-1].qs) * 40'(eul_pkg::SIN_DIV[k]);
            assign n_rc = 40'(r_st[3*k-1].pc)
                        - 40'(r_st[3*k-1].qc) * 40'(eul_pkg::COS_DIV[k]);
            assign n_sq = (n_rs >= 40'(eul_pkg::SIN_DIV[k])) ? r_st[3*k-1].qs + 32'd1
                                                              : r_st[3*k-1].qs;
            assign n_cq = (n_rc >= 40'(eul_pkg::COS_DIV[k])) ? r_st[3*k-1].qc + 32'd1
                                                              : r_st[3*k-1].qc;

            always_comb begin
                n_st_mul    = r_st[3*k-3];
                n_st_mul.ps = n_ps[61:30];
                n_st_mul.pc = n_pc[61:30];
                n_st_rcp    = r_st[3*k-2];
                n_st_rcp.qs = n_qs[63:32];
                n_st_rcp.qc = n_qc[63:32];
                n_st_fix    = r_st[3*k-1];
                n_st_fix.tc = n_cq;
                if (k % 2 == 1) begin
                    n_st_fix.ac = r_st[3*k-1].ac - 34'(n_cq);
                end else begin
                    n_st_fix.ac = r_st[3*k-1].ac + 34'(n_cq);
                end
                if (k <= eul_pkg::SIN_STEPS) begin
                    n_st_fix.ts = n_sq;
                    if (k % 2 == 1) begin
                        n_st_fix.as = r_st[3*k-1].as - 34'(n_sq);
                    end else begin
                        n_st_fix.as = r_st[3*k-1].as + 34'(n_sq);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[3*k-2] <= n_st_mul;
                    r_st[3*k-1] <= n_st_rcp;
                    r_st[3*k]   <= n_st_fix;
                end
            end
        end
    endgenerate

    logic [31:0] n_smag;
    logic [31:0] n_cmag;

    always_comb begin
        if (r_st[NST-1].as < 0) begin
            n_smag = '0;
        end else if (r_st[NST-1].as > 34'(eul_pkg::ONE_Q30)) begin
            n_smag = eul_pkg::ONE_Q30;
        end else begin
            n_smag = r_st[NST-1].as[31:0];
        end
        if (r_st[NST-1].ac < 0) begin
            n_cmag = '0;
        end else if (r_st[NST-1].ac > 34'(eul_pkg::ONE_Q30)) begin
            n_cmag = eul_pkg::ONE_Q30;
        end else begin
            n_cmag = r_st[NST-1].ac[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= r_st[NST-1].neg ? -$signed(n_smag) : $signed(n_smag);
            o_cos <= $signed(n_cmag);
        end
    end

endmodule

// ===== rtl/core/euler_zyx_to_quaternion_top.sv =====
`timescale 1ns / 1ps
// euler zyx angles to quaternion
// input channel: roll, pitch and yaw as signed binary angles (full scale is
// plus or minus pi), taken on i_valid high and o_stall low
// output channel: quaternion w, x, y, z in signed q1.14, each within +-1.0,
// presented on o_valid and taken when i_stall is low
// throughput: one item per cycle while the receiver takes results
// pipeline from acceptance to o_valid: input register, two angle
// setup stages, seven series steps of three stages each (multiply,
// reciprocal multiply, remainder fixup), one clamp stage, and four
// quaternion stages (two products, sum, rounding)
// when a result waits at the output under i_stall, the whole pipeline holds
// and o_stall goes high; nothing is lost or repeated
// reset (synchronous, active low) empties the pipeline; no results follow
// until new items are accepted
module euler_zyx_to_quaternion_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [eul_pkg::IN_WIDTH-1:0]   i_roll_angle,
    input  logic signed [eul_pkg::IN_WIDTH-1:0]   i_pitch_angle,
    input  logic signed [eul_pkg::IN_WIDTH-1:0]   i_yaw_angle,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_quat_w,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_quat_x,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_quat_y,
    output logic signed [eul_pkg::OUT_WIDTH-1:0]  o_quat_z
);

    localparam int VW = eul_pkg::VAL_WIDTH;
    localparam int OW = eul_pkg::OUT_WIDTH;
    localparam int AW = eul_pkg::ANGLE_WIDTH;
    localparam int SH = eul_pkg::IFRAC - eul_pkg::QUAT_FRAC_BITS;

    function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic              neg;
        logic [VW-1:0]     ua;
        logic [VW-1:0]     ub;
        logic [2*VW-1:0]   p;
        logic [VW-1:0]     r;
        neg = a[VW-1] ^ b[VW-1];
        ua  = a[VW-1] ? VW'(-a) : VW'(a);
        ub  = b[VW-1] ? VW'(-b) : VW'(b);
        p   = (2*VW)'(ua) * (2*VW)'(ub) + ((2*VW)'(1) << (eul_pkg::IFRAC - 1));
        r   = p[eul_pkg::IFRAC+VW-1:eul_pkg::IFRAC];
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [OW-1:0] to_out(input logic signed [VW:0] v);
        logic          neg;
        logic [VW:0]   mag;
        logic [VW:0]   rnd;
        logic [OW-1:0] lim;
        neg = v[VW];
        mag = neg ? (VW+1)'(-v) : (VW+1)'(v);
        rnd = (mag + ((VW+1)'(1) << (SH - 1))) >> SH;
        lim = OW'(1) << eul_pkg::QUAT_FRAC_BITS;
        if (rnd > (VW+1)'(lim)) begin
            rnd = (VW+1)'(lim);
        end
        return neg ? -$signed(rnd[OW-1:0]) : $signed(rnd[OW-1:0]);
    endfunction

    logic                               en;
    logic [eul_pkg::PIPE_DEPTH-1:0]     r_vld;
    logic [AW-1:0]                      r_roll;
    logic [AW-1:0]                      r_pitch;
    logic [AW-1:0]                      r_yaw;
    logic signed [VW-1:0]               sr, cr, sp, cp, sy, cy;
    logic signed [VW-1:0]               r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [VW-1:0]               r_cy, r_sy;
    logic signed [VW-1:0]               r_m [0:7];
    logic signed [VW:0]                 r_sw, r_sx, r_sy_sum, r_sz;

    assign en      = !(r_vld[eul_pkg::PIPE_DEPTH-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[eul_pkg::PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[eul_pkg::PIPE_DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= i_roll_angle[AW-1:0];
            r_pitch <= i_pitch_angle[AW-1:0];
            r_yaw   <= i_yaw_angle[AW-1:0];
        end
    end

    eul_sincos u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_roll),
        .o_sin   (sr),
        .o_cos   (cr)
    );

    eul_sincos u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_pitch),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    eul_sincos u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_yaw),
        .o_sin   (sy),
        .o_cos   (cy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crcp   <= mulq(cr, cp);
            r_srsp   <= mulq(sr, sp);
            r_srcp   <= mulq(sr, cp);
            r_crsp   <= mulq(cr, sp);
            r_cy     <= cy;
            r_sy     <= sy;
            r_m[0]   <= mulq(r_crcp, r_cy);
            r_m[1]   <= mulq(r_srsp, r_sy);
            r_m[2]   <= mulq(r_srcp, r_cy);
            r_m[3]   <= mulq(r_crsp, r_sy);
            r_m[4]   <= mulq(r_crsp, r_cy);
            r_m[5]   <= mulq(r_srcp, r_sy);
            r_m[6]   <= mulq(r_crcp, r_sy);
            r_m[7]   <= mulq(r_srsp, r_cy);
            r_sw     <= (VW+1)'(r_m[0]) + (VW+1)'(r_m[1]);
            r_sx     <= (VW+1)'(r_m[2]) - (VW+1)'(r_m[3]);
            r_sy_sum <= (VW+1)'(r_m[4]) + (VW+1)'(r_m[5]);
            r_sz     <= (VW+1)'(r_m[6]) - (VW+1)'(r_m[7]);
            o_quat_w <= to_out(r_sw);
            o_quat_x <= to_out(r_sx);
            o_quat_y <= to_out(r_sy_sum);
            o_quat_z <= to_out(r_sz);
        end
    end

endmodule

// ===== rtl/core/eul_checker.sv =====
`timescale 1ns / 1ps

module eul_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [eul_pkg::OUT_WIDTH-1:0] o_quat_w,
    input logic signed [eul_pkg::OUT_WIDTH-1:0] o_quat_x,
    input logic signed [eul_pkg::OUT_WIDTH-1:0] o_quat_y,
    input logic signed [eul_pkg::OUT_WIDTH-1:0] o_quat_z
);

    localparam logic signed [eul_pkg::OUT_WIDTH-1:0] LIM =
        eul_pkg::OUT_WIDTH'(1) << eul_pkg::QUAT_FRAC_BITS;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_quat_w) && $stable(o_quat_x)
                               && $stable(o_quat_y) && $stable(o_quat_z))
        else $error("stalled item changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_quat_w <= LIM && o_quat_w >= -LIM && o_quat_x <= LIM
                    && o_quat_x >= -LIM && o_quat_y <= LIM && o_quat_y >= -LIM
                    && o_quat_z <= LIM && o_quat_z >= -LIM)
        else $error("component beyond one");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output held");

endmodule

bind euler_zyx_to_quaternion_top eul_checker u_eul_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_quat_w (o_quat_w),
    .o_quat_x (o_quat_x),
    .o_quat_y (o_quat_y),
    .o_quat_z (o_quat_z)
);
